// ----- sv/bsp_pkg.sv -----
// Shared constants for the B-spline surface point evaluator.
// Holds field widths, command and register codes and fixed-point limits.
// No dependencies.
package bsp_pkg;

  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_MAX_ORDER  = 8;

  localparam int CMD_W   = 2;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 5;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 4;
  localparam int KNOT_W  = 16;
  localparam int CRD_W   = 24;
  localparam int CNT_W   = 5;
  localparam int DEG_W   = 3;
  localparam int BAS_W   = 18;
  localparam int SPAN_W  = 17;
  localparam int NUM_W   = 35;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 50;
  localparam int WGT_W   = 21;

  localparam logic [CMD_W-1:0] CMD_KNOT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CTRL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_COUNT_U  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COUNT_V  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DEGREE_U = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_DEGREE_V = 2'd3;

  localparam logic [CNT_W-1:0] RST_COUNT  = 5'd4;
  localparam logic [DEG_W-1:0] RST_DEGREE = 3'd3;

  localparam logic [KNOT_W-1:0] ONE_Q15   = 16'd32768;
  localparam logic [BAS_W-1:0]  BASIS_ONE = 18'd65536;
  localparam int                BASIS_MAX = 262143;

endpackage

// ----- sv/bsp_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Used by the basis recursion of the surface evaluator. Depends on bsp_pkg.
module bsp_div #(
  parameter int NW = bsp_pkg::NUM_W,
  parameter int DW = bsp_pkg::SPAN_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] mag_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dmag_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW-1:0] trial;
  logic          fit;

  // The numerator register doubles as the quotient register as it shifts.
  assign trial = {rem_r[DW-2:0], mag_r[NW-1]};
  assign fit   = (trial >= dmag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mag_r  <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag_r <= den[DW-1] ? DW'(-den) : DW'(den);
        rem_r  <= '0;
        neg_r  <= num[NW-1] ^ den[DW-1];
        cnt_r  <= CW'(NW);
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r <= fit ? (trial - dmag_r) : trial;
        mag_r <= {mag_r[NW-2:0], fit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

// ----- sv/bspline_surface_point_eval_unit.sv -----
// B-spline surface point evaluator, top level.
// Depends on bsp_pkg and bsp_div.
//
// Requests enter on start while busy is low. A knot write (cmd 0), a control
// point write (cmd 1) or the unused code 3 is done at once and its result
// (kind echoed, point fields zero) shows in the next cycle; busy stays low, so
// such requests may come every cycle. An evaluate request (cmd 2) raises busy
// and runs the Cox-de Boor recursion for u and then v, followed by the
// tensor-product sum, all on one shared multiplier and one shared
// bit-serial divider under a small sequencer, which waits on the divider for
// each of the two quotients of a basis term (a term with a zero span skips
// its divide). Reset defaults are 4 points and degree 3. Each result is
// shown for one cycle with out_valid high; for an evaluation busy falls on
// that same cycle; the receiver cannot stall. Configuration writes are taken
// whenever busy is low. Reset sets the register defaults and idles the
// sequencer; knot and control point stores hold no value until written.
module bspline_surface_point_eval_unit #(
  parameter int MAX_POINTS = bsp_pkg::DEF_MAX_POINTS,
  parameter int MAX_ORDER  = bsp_pkg::DEF_MAX_ORDER
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bsp_pkg::CMD_W-1:0]         in_cmd,
  input  logic                              in_direction,
  input  logic [bsp_pkg::ROW_W-1:0]         in_row_index,
  input  logic [bsp_pkg::COL_W-1:0]         in_col_index,
  input  logic [bsp_pkg::KNOT_W-1:0]        in_knot_value,
  input  logic signed [bsp_pkg::CRD_W-1:0]  in_coord_x,
  input  logic signed [bsp_pkg::CRD_W-1:0]  in_coord_y,
  input  logic signed [bsp_pkg::CRD_W-1:0]  in_coord_z,
  input  logic [bsp_pkg::KNOT_W-1:0]        in_param_u,
  input  logic [bsp_pkg::KNOT_W-1:0]        in_param_v,
  output logic                              out_valid,
  output logic [bsp_pkg::CMD_W-1:0]         out_kind,
  output logic signed [bsp_pkg::CRD_W-1:0]  out_point_x,
  output logic signed [bsp_pkg::CRD_W-1:0]  out_point_y,
  output logic signed [bsp_pkg::CRD_W-1:0]  out_point_z,
  output logic                              out_point_nonzero,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsp_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [bsp_pkg::CFG_DW-1:0]        cfg_data
);

  import bsp_pkg::*;

  localparam int KD   = MAX_POINTS + MAX_ORDER;
  localparam int KAW  = $clog2(2 * KD);
  localparam int BAW  = $clog2(KD);
  localparam int IW   = $clog2(KD + 1);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int DGW  = $clog2(MAX_ORDER);
  localparam int NPTS = MAX_POINTS * MAX_POINTS;
  localparam int CAW  = $clog2(NPTS);
  localparam int ACCW = 2 * $clog2(MAX_POINTS) + 46;
  localparam int SW   = NUM_W + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_D0A  = 5'd1;
  localparam logic [4:0] S_D0B  = 5'd2;
  localparam logic [4:0] S_D0C  = 5'd3;
  localparam logic [4:0] S_LA   = 5'd4;
  localparam logic [4:0] S_LB   = 5'd5;
  localparam logic [4:0] S_LC   = 5'd6;
  localparam logic [4:0] S_LD   = 5'd7;
  localparam logic [4:0] S_LE   = 5'd8;
  localparam logic [4:0] S_LF   = 5'd9;
  localparam logic [4:0] S_LG   = 5'd10;
  localparam logic [4:0] S_LH   = 5'd11;
  localparam logic [4:0] S_LI   = 5'd12;
  localparam logic [4:0] S_LJ   = 5'd13;
  localparam logic [4:0] S_LK   = 5'd14;
  localparam logic [4:0] S_LZ   = 5'd15;
  localparam logic [4:0] S_PA   = 5'd16;
  localparam logic [4:0] S_PB   = 5'd17;
  localparam logic [4:0] S_PC   = 5'd18;
  localparam logic [4:0] S_PX   = 5'd19;
  localparam logic [4:0] S_PY   = 5'd20;
  localparam logic [4:0] S_PZ   = 5'd21;
  localparam logic [4:0] S_PN   = 5'd22;
  localparam logic [4:0] S_FIN  = 5'd23;

  // Configuration
  logic [CNT_W-1:0] count_u_r, count_v_r;
  logic [DEG_W-1:0] degree_u_r, degree_v_r;

  // Sequencer
  logic [4:0]      state_r;
  logic            dir_r;
  logic [IW-1:0]   i_r;
  logic [CNTW-1:0] j_r;
  logic [DGW-1:0]  k_r;
  logic [CNTW-1:0] cu_r, cv_r;
  logic [DGW-1:0]  du_r, dv_r;
  logic [KNOT_W-1:0] pu_r, pv_r;

  // Working registers
  logic [KNOT_W-1:0] ta_r, ti_r, ti1_r, tik_r, tik1_r;
  logic [BAS_W-1:0]  bi_r, bi1_r;
  logic signed [SW-1:0]     s_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [WGT_W-1:0]         w_r;
  logic signed [ACCW-1:0]   acc_x_r, acc_y_r, acc_z_r;

  // Stores
  logic [KNOT_W-1:0] knot_mem [2*KD];
  logic [KNOT_W-1:0] kq_r;
  logic [BAS_W-1:0]  bu_mem [KD];
  logic [BAS_W-1:0]  bv_mem [KD];
  logic [BAS_W-1:0]  bu_q_r, bv_q_r;
  logic signed [CRD_W-1:0] cx_mem [NPTS];
  logic signed [CRD_W-1:0] cy_mem [NPTS];
  logic signed [CRD_W-1:0] cz_mem [NPTS];
  logic signed [CRD_W-1:0] cx_q_r, cy_q_r, cz_q_r;

  // Results
  logic                    out_valid_r;
  logic [CMD_W-1:0]        out_kind_r;
  logic signed [CRD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_nz_r;

  // Combinational
  logic              accept;
  logic [IW-1:0]     nk;
  logic [DGW-1:0]    cur_deg;
  logic [KNOT_W-1:0] cur_u;
  logic signed [SPAN_W-1:0] u_s;
  logic [IW-1:0]     kidx, bidx_u, bidx_v, b_waddr;
  logic [KAW-1:0]    kaddr;
  logic              b_we;
  logic [BAS_W-1:0]  b_wdata;
  logic [BAS_W-1:0]  bq;
  logic [CAW-1:0]    caddr_rd;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic              div_start, div_done;
  logic signed [SPAN_W-1:0] div_den;
  logic signed [NUM_W-1:0]  div_quot;
  logic signed [SPAN_W-1:0] span1, span2;
  logic [IW-1:0]     i_inc;
  logic              d0_in;
  logic [KNOT_W-1:0] kv_sat;
  logic signed [CRD_W-1:0] fx, fy, fz;
  logic [CNTW-1:0]   cu_cl, cv_cl;
  logic [DGW-1:0]    du_cl, dv_cl;

  function automatic logic signed [CRD_W-1:0] finish_acc(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-1:0] r;
    r = (acc + ACCW'(32768)) >>> 16;
    if (r > ACCW'(8388607)) r = ACCW'(8388607);
    if (r < ACCW'(-8388608)) r = ACCW'(-8388608);
    return CRD_W'(r);
  endfunction

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  assign cu_cl = (count_u_r < 2) ? CNTW'(2) :
                 (count_u_r > MAX_POINTS) ? CNTW'(MAX_POINTS) : CNTW'(count_u_r);
  assign cv_cl = (count_v_r < 2) ? CNTW'(2) :
                 (count_v_r > MAX_POINTS) ? CNTW'(MAX_POINTS) : CNTW'(count_v_r);
  assign du_cl = (degree_u_r < 1) ? DGW'(1) :
                 (degree_u_r > MAX_ORDER - 1) ? DGW'(MAX_ORDER - 1) : DGW'(degree_u_r);
  assign dv_cl = (degree_v_r < 1) ? DGW'(1) :
                 (degree_v_r > MAX_ORDER - 1) ? DGW'(MAX_ORDER - 1) : DGW'(degree_v_r);

  assign cur_deg = dir_r ? dv_r : du_r;
  assign cur_u   = dir_r ? pv_r : pu_r;
  assign nk      = dir_r ? (IW'(cv_r) + IW'(dv_r) + IW'(1))
                         : (IW'(cu_r) + IW'(du_r) + IW'(1));
  assign u_s     = $signed({1'b0, cur_u});
  assign span1   = $signed({1'b0, tik_r}) - $signed({1'b0, ti_r});
  assign span2   = $signed({1'b0, tik1_r}) - $signed({1'b0, ti1_r});
  assign i_inc   = i_r + IW'(1);
  assign bq      = dir_r ? bv_q_r : bu_q_r;
  assign kaddr   = KAW'(dir_r ? KD : 0) + KAW'(kidx);
  assign caddr_rd = CAW'(i_r * MAX_POINTS + j_r);
  assign kv_sat  = (in_knot_value > ONE_Q15) ? ONE_Q15 : in_knot_value;

  // Degree-0 interval test; closed on the right when the parameter is one.
  assign d0_in = (cur_u == ONE_Q15) ? ((cur_u > ta_r) && (cur_u <= kq_r))
                                    : ((cur_u >= ta_r) && (cur_u < kq_r));

  always_comb begin
    kidx      = i_r;
    bidx_u    = i_r;
    bidx_v    = i_r;
    b_we      = 1'b0;
    b_waddr   = i_r;
    b_wdata   = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_den   = span1;
    case (state_r)
      S_D0B: kidx = i_inc;
      S_D0C: begin
        b_we    = 1'b1;
        b_wdata = d0_in ? BASIS_ONE : '0;
      end
      S_LB: begin
        kidx   = i_inc;
        bidx_u = i_inc;
        bidx_v = i_inc;
      end
      S_LC: kidx = i_r + IW'(k_r);
      S_LD: kidx = i_r + IW'(k_r) + IW'(1);
      S_LE: begin
        mul_a = MUL_W'($signed({1'b0, bi_r}));
        mul_b = MUL_W'(u_s - $signed({1'b0, ti_r}));
      end
      S_LF: begin
        div_start = (span1 != 0);
        div_den   = span1;
      end
      S_LH: begin
        mul_a = MUL_W'($signed({1'b0, bi1_r}));
        mul_b = MUL_W'($signed({1'b0, tik1_r}) - u_s);
      end
      S_LI: begin
        div_start = (span2 != 0);
        div_den   = span2;
      end
      S_LK: begin
        b_we = 1'b1;
        if (s_r < 0) b_wdata = '0;
        else if (s_r > BASIS_MAX) b_wdata = BAS_W'(BASIS_MAX);
        else b_wdata = BAS_W'(s_r);
      end
      S_LZ: begin
        b_we    = 1'b1;
        b_waddr = nk - IW'(1) - IW'(k_r);
        b_wdata = '0;
      end
      S_PA: begin
        bidx_u = i_r;
        bidx_v = IW'(j_r);
      end
      S_PB: begin
        bidx_v = IW'(j_r);
        mul_a  = MUL_W'($signed({1'b0, bu_q_r}));
        mul_b  = MUL_W'($signed({1'b0, bv_q_r}));
      end
      S_PC, S_PN: bidx_v = IW'(j_r);
      S_PX: begin
        bidx_v = IW'(j_r);
        mul_a  = MUL_W'(cx_q_r);
        mul_b  = MUL_W'($signed({1'b0, w_r}));
      end
      S_PY: begin
        bidx_v = IW'(j_r);
        mul_a  = MUL_W'(cy_q_r);
        mul_b  = MUL_W'($signed({1'b0, w_r}));
      end
      S_PZ: begin
        bidx_v = IW'(j_r);
        mul_a  = MUL_W'(cz_q_r);
        mul_b  = MUL_W'($signed({1'b0, w_r}));
      end
      default: ;
    endcase
  end

  bsp_div #(.NW(NUM_W), .DW(SPAN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[NUM_W-1:0]),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a * mul_b);
  end

  // Stores, registered reads.
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_KNOT && in_row_index < KD)
      knot_mem[KAW'(in_direction ? KD : 0) + KAW'(in_row_index)] <= kv_sat;
    kq_r <= knot_mem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (b_we && !dir_r) bu_mem[BAW'(b_waddr)] <= b_wdata;
    if (b_we && dir_r)  bv_mem[BAW'(b_waddr)] <= b_wdata;
    bu_q_r <= bu_mem[BAW'(bidx_u)];
    bv_q_r <= bv_mem[BAW'(bidx_v)];
  end

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_CTRL && in_row_index < MAX_POINTS &&
        in_col_index < MAX_POINTS) begin
      cx_mem[CAW'(in_row_index * MAX_POINTS + in_col_index)] <= in_coord_x;
      cy_mem[CAW'(in_row_index * MAX_POINTS + in_col_index)] <= in_coord_y;
      cz_mem[CAW'(in_row_index * MAX_POINTS + in_col_index)] <= in_coord_z;
    end
    cx_q_r <= cx_mem[caddr_rd];
    cy_q_r <= cy_mem[caddr_rd];
    cz_q_r <= cz_mem[caddr_rd];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_u_r  <= RST_COUNT;
      count_v_r  <= RST_COUNT;
      degree_u_r <= RST_DEGREE;
      degree_v_r <= RST_DEGREE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COUNT_U:  count_u_r  <= CNT_W'(cfg_data);
        CFG_COUNT_V:  count_v_r  <= CNT_W'(cfg_data);
        CFG_DEGREE_U: degree_u_r <= DEG_W'(cfg_data);
        CFG_DEGREE_V: degree_v_r <= DEG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign fx = finish_acc(acc_x_r);
  assign fy = finish_acc(acc_y_r);
  assign fz = finish_acc(acc_z_r);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_kind_r <= in_cmd;
            out_x_r    <= '0;
            out_y_r    <= '0;
            out_z_r    <= '0;
            out_nz_r   <= 1'b0;
            if (in_cmd == CMD_EVAL) begin
              pu_r    <= (in_param_u > ONE_Q15) ? ONE_Q15 : in_param_u;
              pv_r    <= (in_param_v > ONE_Q15) ? ONE_Q15 : in_param_v;
              cu_r    <= cu_cl;
              cv_r    <= cv_cl;
              du_r    <= du_cl;
              dv_r    <= dv_cl;
              dir_r   <= 1'b0;
              i_r     <= '0;
              acc_x_r <= '0;
              acc_y_r <= '0;
              acc_z_r <= '0;
              state_r <= S_D0A;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_D0A: state_r <= S_D0B;
        S_D0B: begin
          ta_r    <= kq_r;
          state_r <= S_D0C;
        end
        S_D0C: begin
          if (i_inc + IW'(1) < nk) begin
            i_r     <= i_inc;
            state_r <= S_D0A;
          end else begin
            i_r     <= '0;
            k_r     <= DGW'(1);
            state_r <= S_LA;
          end
        end
        S_LA: state_r <= S_LB;
        S_LB: begin
          ti_r    <= kq_r;
          bi_r    <= bq;
          state_r <= S_LC;
        end
        S_LC: begin
          ti1_r   <= kq_r;
          bi1_r   <= bq;
          state_r <= S_LD;
        end
        S_LD: begin
          tik_r   <= kq_r;
          state_r <= S_LE;
        end
        S_LE: begin
          tik1_r  <= kq_r;
          state_r <= S_LF;
        end
        S_LF: begin
          s_r     <= '0;
          state_r <= (span1 != 0) ? S_LG : S_LH;
        end
        S_LG: begin
          if (div_done) begin
            s_r     <= SW'(div_quot);
            state_r <= S_LH;
          end
        end
        S_LH: state_r <= S_LI;
        S_LI: state_r <= (span2 != 0) ? S_LJ : S_LK;
        S_LJ: begin
          if (div_done) begin
            s_r     <= s_r + SW'(div_quot);
            state_r <= S_LK;
          end
        end
        S_LK: begin
          if (i_inc + IW'(1) + IW'(k_r) < nk) begin
            i_r     <= i_inc;
            state_r <= S_LA;
          end else begin
            state_r <= S_LZ;
          end
        end
        S_LZ: begin
          i_r <= '0;
          if (k_r == cur_deg) begin
            if (!dir_r) begin
              dir_r   <= 1'b1;
              state_r <= S_D0A;
            end else begin
              j_r     <= '0;
              state_r <= S_PA;
            end
          end else begin
            k_r     <= k_r + DGW'(1);
            state_r <= S_LA;
          end
        end
        S_PA: state_r <= S_PB;
        S_PB: state_r <= S_PC;
        S_PC: begin
          // Weight is the rounded Q.16 product of the two basis values.
          w_r     <= WGT_W'((prod_r + PROD_W'(32768)) >>> 16);
          state_r <= S_PX;
        end
        S_PX: state_r <= S_PY;
        S_PY: begin
          acc_x_r <= acc_x_r + ACCW'(prod_r);
          state_r <= S_PZ;
        end
        S_PZ: begin
          acc_y_r <= acc_y_r + ACCW'(prod_r);
          state_r <= S_PN;
        end
        S_PN: begin
          acc_z_r <= acc_z_r + ACCW'(prod_r);
          if (j_r + CNTW'(1) < cv_r) begin
            j_r     <= j_r + CNTW'(1);
            state_r <= S_PA;
          end else if (i_inc < IW'(cu_r)) begin
            j_r     <= '0;
            i_r     <= i_inc;
            state_r <= S_PA;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_x_r     <= fx;
          out_y_r     <= fy;
          out_z_r     <= fz;
          out_nz_r    <= (fx != 0) || (fy != 0) || (fz != 0);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_point_x       = out_x_r;
  assign out_point_y       = out_y_r;
  assign out_point_z       = out_z_r;
  assign out_point_nonzero = out_nz_r;

endmodule

// ----- sv/bsp_chk.sv -----
// Port-level checker for the B-spline surface point evaluator and its bind.
// Depends on bsp_pkg and bspline_surface_point_eval_unit.
module bsp_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [bsp_pkg::CMD_W-1:0]        in_cmd,
  input logic                             out_valid,
  input logic [bsp_pkg::CMD_W-1:0]        out_kind,
  input logic signed [bsp_pkg::CRD_W-1:0] out_point_x,
  input logic signed [bsp_pkg::CRD_W-1:0] out_point_y,
  input logic signed [bsp_pkg::CRD_W-1:0] out_point_z,
  input logic                             out_point_nonzero
);

  import bsp_pkg::*;

  // A write or unused-code request answers in the next cycle with its own code.
  a_write_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd != CMD_EVAL |=> out_valid && out_kind == $past(in_cmd))
    else $error("write request not answered in the next cycle");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_EVAL |=> busy && !out_valid)
    else $error("evaluate request did not raise busy");

  // An evaluation ends exactly when its result is shown.
  a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_kind == CMD_EVAL)
    else $error("busy fell without an evaluate result");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != CMD_EVAL |->
      out_point_x == 0 && out_point_y == 0 && out_point_z == 0 && !out_point_nonzero)
    else $error("non-evaluate result carries a point");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_point_nonzero == (out_point_x != 0 || out_point_y != 0 || out_point_z != 0))
    else $error("nonzero flag disagrees with the point");

endmodule

bind bspline_surface_point_eval_unit bsp_chk u_bsp_chk (.*);

// ----- verif/tb.sv -----
// Testbench for the B-spline surface point evaluator.
// Drives knot, control point and evaluate requests, predicts every result
// from its own copy of the stores and registers; depends on bsp_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int KNOTS = DEF_MAX_POINTS + DEF_MAX_ORDER;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic                    dir;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [KNOT_W-1:0]       knot;
    logic signed [CRD_W-1:0] x, y, z;
    logic [KNOT_W-1:0]       pu, pv;
  } bsp_req_t;

  typedef struct {
    logic [CMD_W-1:0]        kind;
    logic signed [CRD_W-1:0] x, y, z;
    logic                    nz;
  } surf_point_t;

  logic clk, rst_n, start, busy;
  logic [CMD_W-1:0] in_cmd;
  logic in_direction;
  logic [ROW_W-1:0] in_row_index;
  logic [COL_W-1:0] in_col_index;
  logic [KNOT_W-1:0] in_knot_value, in_param_u, in_param_v;
  logic signed [CRD_W-1:0] in_coord_x, in_coord_y, in_coord_z;
  logic out_valid, out_point_nonzero;
  logic [CMD_W-1:0] out_kind;
  logic signed [CRD_W-1:0] out_point_x, out_point_y, out_point_z;
  logic cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  bspline_surface_point_eval_unit DUT (.*);

  bsp_req_t    pending_reqs[$];
  surf_point_t expected_points[$];
  int errors;
  int send_idle_pct;
  int idle_cycles;
  logic taken;

  // Predictor state.
  logic [CNT_W-1:0] cnt_u_reg, cnt_v_reg;
  logic [DEG_W-1:0] deg_u_reg, deg_v_reg;
  logic [KNOT_W-1:0] knot_mem[2][KNOTS];
  logic signed [CRD_W-1:0] ctrl_x[256], ctrl_y[256], ctrl_z[256];
  longint basis[2][KNOTS];

  function automatic int eff_count(int raw);
    return raw < 2 ? 2 : (raw > DEF_MAX_POINTS ? DEF_MAX_POINTS : raw);
  endfunction

  function automatic int eff_degree(int raw);
    return raw < 1 ? 1 : (raw > DEF_MAX_ORDER - 1 ? DEF_MAX_ORDER - 1 : raw);
  endfunction

  function automatic void build_basis(int d, longint u, int cnt, int deg);
    int nk;
    longint a, c, s, sp1, sp2;
    nk = cnt + deg + 1;
    for (int i = 0; i < KNOTS; i++) basis[d][i] = 0;
    for (int i = 0; i + 1 < nk; i++) begin
      a = longint'(knot_mem[d][i]);
      c = longint'(knot_mem[d][i+1]);
      // Degree-0 intervals close on the right only at the end of the range.
      if (u != 32768) basis[d][i] = (u >= a && u < c) ? 65536 : 0;
      else basis[d][i] = (u > a && u <= c) ? 65536 : 0;
    end
    for (int k = 1; k <= deg; k++) begin
      for (int i = 0; i + 1 + k < nk; i++) begin
        s = 0;
        sp1 = longint'(knot_mem[d][i+k]) - longint'(knot_mem[d][i]);
        sp2 = longint'(knot_mem[d][i+k+1]) - longint'(knot_mem[d][i+1]);
        if (sp1 != 0) s += (basis[d][i] * (u - longint'(knot_mem[d][i]))) / sp1;
        if (sp2 != 0) s += (basis[d][i+1] * (longint'(knot_mem[d][i+k+1]) - u)) / sp2;
        if (s < 0) s = 0;
        if (s > BASIS_MAX) s = BASIS_MAX;
        basis[d][i] = s;
      end
      basis[d][nk-1-k] = 0;
    end
  endfunction

  function automatic logic signed [CRD_W-1:0] round_coord(longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[CRD_W-1:0];
  endfunction

  function automatic surf_point_t evaluate_request(bsp_req_t r);
    surf_point_t p;
    int cu, cv, a;
    longint pu, pv, w, ax, ay, az;
    p.kind = r.cmd; p.x = '0; p.y = '0; p.z = '0; p.nz = 1'b0;
    case (r.cmd)
      CMD_KNOT: begin
        if (r.row < KNOTS) knot_mem[r.dir][r.row] = (r.knot > ONE_Q15) ? ONE_Q15 : r.knot;
      end
      CMD_CTRL: begin
        if (r.row < DEF_MAX_POINTS) begin
          a = r.row * DEF_MAX_POINTS + r.col;
          ctrl_x[a] = r.x; ctrl_y[a] = r.y; ctrl_z[a] = r.z;
        end
      end
      CMD_EVAL: begin
        cu = eff_count(cnt_u_reg); cv = eff_count(cnt_v_reg);
        pu = (r.pu > ONE_Q15) ? 32768 : longint'(r.pu);
        pv = (r.pv > ONE_Q15) ? 32768 : longint'(r.pv);
        build_basis(0, pu, cu, eff_degree(deg_u_reg));
        build_basis(1, pv, cv, eff_degree(deg_v_reg));
        ax = 0; ay = 0; az = 0;
        for (int i = 0; i < cu; i++) begin
          for (int j = 0; j < cv; j++) begin
            w = (basis[0][i] * basis[1][j] + 32768) / 65536;
            a = i * DEF_MAX_POINTS + j;
            ax += longint'(ctrl_x[a]) * w;
            ay += longint'(ctrl_y[a]) * w;
            az += longint'(ctrl_z[a]) * w;
          end
        end
        p.x = round_coord(ax); p.y = round_coord(ay); p.z = round_coord(az);
        p.nz = (p.x != 0) || (p.y != 0) || (p.z != 0);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic queue_req(bsp_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: holds a request until it is taken, then moves to the next one.
  always @(negedge clk) begin
    bsp_req_t r;
    if (rst_n && !(start && !taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_cmd <= r.cmd; in_direction <= r.dir;
        in_row_index <= r.row; in_col_index <= r.col;
        in_knot_value <= r.knot;
        in_coord_x <= r.x; in_coord_y <= r.y; in_coord_z <= r.z;
        in_param_u <= r.pu; in_param_v <= r.pv;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on acceptance, checks every strobed result.
  always @(posedge clk) begin
    bsp_req_t r;
    surf_point_t want;
    taken <= start && !busy;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNT_U:  cnt_u_reg <= cfg_data;
          CFG_COUNT_V:  cnt_v_reg <= cfg_data;
          CFG_DEGREE_U: deg_u_reg <= cfg_data[DEG_W-1:0];
          CFG_DEGREE_V: deg_v_reg <= cfg_data[DEG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          report("unexpected result, kind", out_kind, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_kind !== want.kind) report("kind", out_kind, want.kind);
          if (out_point_x !== want.x) report("point_x", out_point_x, want.x);
          if (out_point_y !== want.y) report("point_y", out_point_y, want.y);
          if (out_point_z !== want.z) report("point_z", out_point_z, want.z);
          if (out_point_nonzero !== want.nz)
            report("point_nonzero", out_point_nonzero, want.nz);
        end
      end
      if (start && !busy) begin
        r.cmd = in_cmd; r.dir = in_direction; r.row = in_row_index;
        r.col = in_col_index; r.knot = in_knot_value;
        r.x = in_coord_x; r.y = in_coord_y; r.z = in_coord_z;
        r.pu = in_param_u; r.pv = in_param_v;
        expected_points.insert(expected_points.size(), evaluate_request(r));
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic bsp_req_t blank_req(logic [CMD_W-1:0] cmd);
    bsp_req_t r;
    r.cmd = cmd; r.dir = 1'($urandom); r.row = ROW_W'($urandom);
    r.col = COL_W'($urandom); r.knot = KNOT_W'($urandom);
    r.x = CRD_W'($urandom); r.y = CRD_W'($urandom); r.z = CRD_W'($urandom);
    r.pu = KNOT_W'($urandom); r.pv = KNOT_W'($urandom);
    return r;
  endfunction

  task automatic push_knot(int d, int row, int value);
    bsp_req_t r;
    r = blank_req(CMD_KNOT);
    r.dir = 1'(d); r.row = ROW_W'(row); r.knot = KNOT_W'(value);
    queue_req(r);
  endtask

  task automatic push_ctrl(int row, int col);
    bsp_req_t r;
    r = blank_req(CMD_CTRL);
    r.row = ROW_W'(row); r.col = COL_W'(col);
    queue_req(r);
  endtask

  task automatic push_eval(int pu, int pv);
    bsp_req_t r;
    r = blank_req(CMD_EVAL);
    r.pu = KNOT_W'(pu); r.pv = KNOT_W'(pv);
    queue_req(r);
  endtask

  // Clamped knot vector over the entries the shape reads, with an occasional
  // repeated interior knot so that zero spans appear inside the range too.
  task automatic push_knot_vector(int d, int raw_cnt, int raw_deg);
    int cnt, deg, value, prev;
    cnt = eff_count(raw_cnt); deg = eff_degree(raw_deg);
    prev = 0;
    for (int i = 0; i < cnt + deg + 1; i++) begin
      if (i <= deg) value = 0;
      else if (i >= cnt) value = 32768;
      else if ($urandom_range(0, 5) == 0) value = prev;
      else value = ((i - deg) * 32768) / (cnt - deg) + $urandom_range(0, 200);
      if (value < prev) value = prev;
      if (value > 32768) value = 32768;
      push_knot(d, i, value);
      prev = value;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_points.size() != 0 || start)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= CFG_DW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(int cu, int cv, int du, int dv);
    drain();
    write_reg(CFG_COUNT_U, cu);
    write_reg(CFG_COUNT_V, cv);
    write_reg(CFG_DEGREE_U, du);
    write_reg(CFG_DEGREE_V, dv);
    push_knot_vector(0, cu, du);
    push_knot_vector(1, cv, dv);
  endtask

  function automatic int rand_param();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 32768);
  endfunction

  initial begin
    int cu, cv, du, dv, pick;
    bsp_req_t r;
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_cmd = 0; in_direction = 0; in_row_index = 0; in_col_index = 0;
    in_knot_value = 0; in_coord_x = 0; in_coord_y = 0; in_coord_z = 0;
    in_param_u = 0; in_param_v = 0;
    errors = 0; idle_cycles = 0; taken = 0; send_idle_pct = 15;
    cnt_u_reg = RST_COUNT; cnt_v_reg = RST_COUNT;
    deg_u_reg = RST_DEGREE; deg_v_reg = RST_DEGREE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Fill every control point that any shape below reads, so no evaluation
    // sees an unwritten one: two full rows, two full columns and a 6x6 corner.
    for (int i = 0; i < DEF_MAX_POINTS; i++)
      for (int j = 0; j < DEF_MAX_POINTS; j++)
        if (i < 2 || j < 2 || (i < 6 && j < 6)) push_ctrl(i, j);

    // Smallest shape and the directed cases.
    set_shape(2, 2, 1, 1);
    push_eval(0, 0);
    push_eval(32768, 32768);
    push_eval(32768, 0);
    push_eval(65535, 40000);
    push_eval(16384, 8192);
    r = blank_req(CMD_CTRL);
    r.row = 0; r.col = 0; r.x = 24'sh7FFFFF; r.y = -24'sh800000; r.z = '0;
    queue_req(r);
    r.col = 1; r.x = -24'sh800000; r.y = 24'sh7FFFFF; r.z = 24'sh7FFFFF;
    queue_req(r);
    push_eval(0, 0);
    push_eval(0, 32768);
    push_ctrl(31, 15);
    push_ctrl(16, 0);
    push_knot(1, 31, 16'hFFFF);
    push_knot(0, 24, 1234);
    push_knot(1, 23, 16'hFFFF);
    push_knot(0, 0, 0);
    queue_req(blank_req(CMD_UNUSED));
    push_eval(32767, 1);
    push_eval(0, 0);

    // Longest knot vector in u, then most points in v; the register values
    // lie partly outside the legal range and are clamped or cut by the block.
    set_shape(31, 0, 7, 15);
    for (int i = 0; i < 3; i++) push_eval(rand_param(), rand_param());
    push_eval(32768, 32768);
    set_shape(1, 16, 0, 9);
    for (int i = 0; i < 4; i++) push_eval(rand_param(), rand_param());

    for (int chunk = 0; chunk < 5; chunk++) begin
      send_idle_pct = (chunk < 2) ? 15 : ((chunk < 4) ? 61 : 0);
      cu = $urandom_range(2, 6); cv = $urandom_range(2, 6);
      du = $urandom_range(1, 3); dv = $urandom_range(1, 3);
      set_shape(cu, cv, du, dv);
      for (int n = 0; n < 16; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) push_knot_vector($urandom_range(0, 1), cu, dv);
        if (pick < 35) push_eval(rand_param(), rand_param());
        else if (pick < 75) push_ctrl($urandom_range(0, 17), $urandom_range(0, 15));
        else if (pick < 93)
          push_knot($urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 65535));
        else queue_req(blank_req(CMD_UNUSED));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/bsp_pkg.sv
sv/bsp_div.sv
sv/bspline_surface_point_eval_unit.sv
sv/bsp_chk.sv
verif/tb.sv
